// ----- rtl/cis_pkg.sv -----
// ----------------------------------------------------------------------------
// cis_pkg - shared constants and helpers for the substring search
// Register indexes, field widths and the ASCII case fold used by the
// search datapath and its stream interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package cis_pkg;

   // default window depth in bytes
   localparam int NEEDLE_MAX_DEF = 32;

   // needle storage: four 64-bit registers, eight bytes each
   localparam int NEEDLE_WORDS = 4;
   localparam int WORD_W       = 64;
   localparam int WORD_BYTES   = 8;

   // field widths
   localparam int BYTE_W    = 8;
   localparam int LEN_REG_W = 6;
   localparam int POS_W     = 31;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_LEN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_OFFSET = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_0     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_1     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_2     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_3     = 3'd5;

   // largest position value
   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

   // map upper-case ASCII letters onto lower case, pass all else
   function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
      logic [BYTE_W-1:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c | 8'h20;
      end
      return r;
   endfunction

   // fold every byte of a needle register word
   function automatic logic [WORD_W-1:0] fold_word(input logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] r;
      for (int i = 0; i < WORD_BYTES; i++) begin
         r[i*BYTE_W +: BYTE_W] = fold_case(w[i*BYTE_W +: BYTE_W]);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/cis_req_if.sv -----
// ----------------------------------------------------------------------------
// cis_req_if - haystack byte channel
// One haystack byte per word, with a flag on the final byte of a stream.
// ----------------------------------------------------------------------------
`default_nettype none

interface cis_req_if;
   import cis_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              last;

   modport source (output valid, output data_byte, output last, input ready);
   modport sink   (input valid, input data_byte, input last, output ready);

endinterface

`default_nettype wire

// ----- rtl/cis_rsp_if.sv -----
// ----------------------------------------------------------------------------
// cis_rsp_if - search result channel
// One word per stream: found flag and absolute start position.
// ----------------------------------------------------------------------------
`default_nettype none

interface cis_rsp_if;
   import cis_pkg::*;

   logic             valid;
   logic             ready;
   logic             found;
   logic [POS_W-1:0] match_index;

   modport source (output valid, output found, output match_index, input ready);
   modport sink   (input valid, input found, input match_index, output ready);

endinterface

`default_nettype wire

// ----- rtl/cis_window_cmp.sv -----
// ----------------------------------------------------------------------------
// cis_window_cmp - parallel window compare
// Aligns the newest needle_len window bytes against the needle with one
// byte-granular barrel shift and compares all positions at once.
// ----------------------------------------------------------------------------
`default_nettype none

module cis_window_cmp #(
   parameter int NEEDLE_MAX = cis_pkg::NEEDLE_MAX_DEF,
   parameter int LEN_W      = $clog2(NEEDLE_MAX + 1)
) (
   input  logic [NEEDLE_MAX*cis_pkg::BYTE_W-1:0] window_vec,
   input  logic [NEEDLE_MAX*cis_pkg::BYTE_W-1:0] needle_vec,
   input  logic [LEN_W-1:0]                      needle_len,
   input  logic [cis_pkg::POS_W-1:0]             byte_count,
   output logic                                  hit
);
   import cis_pkg::*;

   localparam int WIN_W = NEEDLE_MAX * BYTE_W;

   logic [WIN_W-1:0]      rev_vec;
   logic [WIN_W-1:0]      aligned_vec;
   logic [LEN_W-1:0]      shift_bytes;
   logic [NEEDLE_MAX-1:0] eq_vec;
   logic                  count_ok;

   // reverse byte order so the oldest byte sits lowest
   for (genvar i = 0; i < NEEDLE_MAX; i++) begin : g_rev
      assign rev_vec[i*BYTE_W +: BYTE_W] = window_vec[(NEEDLE_MAX-1-i)*BYTE_W +: BYTE_W];
   end

   // drop the bytes older than the needle: byte j then holds window[len-1-j]
   assign shift_bytes = LEN_W'(NEEDLE_MAX) - needle_len;
   assign aligned_vec = rev_vec >> {shift_bytes, 3'b000};

   // compare each needle position, positions past the length always agree
   for (genvar j = 0; j < NEEDLE_MAX; j++) begin : g_eq
      assign eq_vec[j] = (aligned_vec[j*BYTE_W +: BYTE_W] == needle_vec[j*BYTE_W +: BYTE_W])
                         || (32'(j) >= 32'(needle_len));
   end

   // a match needs at least needle_len bytes seen in this stream
   assign count_ok = byte_count >= POS_W'(needle_len);
   assign hit      = (needle_len == '0) || (count_ok && (&eq_vec));

endmodule

`default_nettype wire

// ----- rtl/case_insensitive_substring_search.sv -----
// ----------------------------------------------------------------------------
// case_insensitive_substring_search - streaming needle search
// The result word is registered from the accepted byte that decides it and
// shows on rsp_bus in the next cycle. Throughput: one byte per cycle while
// no result word waits, set by the combinational window compare. A result
// word that waits untaken holds off the input; one taken in the same cycle lets
// the next byte in. Synchronous active-high reset clears the configuration registers, window, count and result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module case_insensitive_substring_search #(
   parameter int NEEDLE_MAX = cis_pkg::NEEDLE_MAX_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   cis_req_if.sink                          req_bus,
   cis_rsp_if.source                        rsp_bus,
   input  logic                             csr_we,
   input  logic [cis_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cis_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import cis_pkg::*;

   localparam int WIN_W        = NEEDLE_MAX * BYTE_W;
   localparam int LEN_W        = $clog2(NEEDLE_MAX + 1);
   localparam int NEEDLE_BYTES = NEEDLE_WORDS * WORD_BYTES;

   // configuration registers, needle kept case-folded
   logic [LEN_REG_W-1:0] needle_len_ff;
   logic [POS_W-1:0]     start_offset_ff;
   logic [WORD_W-1:0]    needle_word_ff [NEEDLE_WORDS];

   // stream state
   logic [WIN_W-1:0] win_ff, win_in;
   logic [POS_W-1:0] count_ff, count_in;
   logic             reported_ff, reported_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             found_ff, found_in;
   logic [POS_W-1:0] index_ff, index_in;

   logic             accept;
   logic [WIN_W-1:0] win_shift;
   logic [WIN_W-1:0] needle_vec;
   logic [POS_W-1:0] count_next;
   logic [31:0]      len_wide;
   logic [LEN_W-1:0] len_c;
   logic [POS_W+1:0] pos_sum;
   logic [POS_W-1:0] pos_sat;
   logic             hit;

   // configuration writes, unknown indexes dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         needle_len_ff   <= '0;
         start_offset_ff <= '0;
         for (int w = 0; w < NEEDLE_WORDS; w++) begin
            needle_word_ff[w] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            CSR_NEEDLE_LEN:   needle_len_ff     <= csr_wdata[LEN_REG_W-1:0];
            CSR_START_OFFSET: start_offset_ff   <= csr_wdata[POS_W-1:0];
            CSR_NEEDLE_0:     needle_word_ff[0] <= fold_word(csr_wdata);
            CSR_NEEDLE_1:     needle_word_ff[1] <= fold_word(csr_wdata);
            CSR_NEEDLE_2:     needle_word_ff[2] <= fold_word(csr_wdata);
            CSR_NEEDLE_3:     needle_word_ff[3] <= fold_word(csr_wdata);
            default: ;
         endcase
      end
   end

   // flatten the needle, bytes past the stored ones read as zero
   for (genvar j = 0; j < NEEDLE_MAX; j++) begin : g_needle
      if (j < NEEDLE_BYTES) begin : g_stored
         assign needle_vec[j*BYTE_W +: BYTE_W] =
            needle_word_ff[j / WORD_BYTES][(j % WORD_BYTES)*BYTE_W +: BYTE_W];
      end else begin : g_zero
         assign needle_vec[j*BYTE_W +: BYTE_W] = '0;
      end
   end

   // clamp the length to the window depth
   always_comb begin
      len_wide = 32'(needle_len_ff);
      if (len_wide > 32'(NEEDLE_MAX)) begin
         len_wide = 32'(NEEDLE_MAX);
      end
   end
   assign len_c = LEN_W'(len_wide);

   // shift the folded byte in, newest lowest, and advance the count
   assign win_shift  = {win_ff[WIN_W-BYTE_W-1:0], fold_case(req_bus.data_byte)};
   assign count_next = (count_ff == POS_MAX) ? POS_MAX : count_ff + 1'b1;

   cis_window_cmp #(
      .NEEDLE_MAX (NEEDLE_MAX),
      .LEN_W      (LEN_W)
   ) u_cmp (
      .window_vec (win_shift),
      .needle_vec (needle_vec),
      .needle_len (len_c),
      .byte_count (count_next),
      .hit        (hit)
   );

   // match start position, saturated at the largest index
   always_comb begin
      if (len_c == '0) begin
         pos_sum = {2'b00, start_offset_ff};
      end else begin
         pos_sum = {2'b00, start_offset_ff} + {2'b00, count_next} - (POS_W+2)'(len_c);
      end
      pos_sat = (pos_sum[POS_W+1:POS_W] != 2'b00) ? POS_MAX : pos_sum[POS_W-1:0];
   end

   // take a byte whenever the result register is free or draining
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   // next stream state and result word
   always_comb begin
      win_in       = win_ff;
      count_in     = count_ff;
      reported_in  = reported_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      found_in     = found_ff;
      index_in     = index_ff;
      if (accept) begin
         if (!reported_ff) begin
            win_in   = win_shift;
            count_in = count_next;
            if (hit) begin
               reported_in  = 1'b1;
               rsp_valid_in = 1'b1;
               found_in     = 1'b1;
               index_in     = pos_sat;
            end else if (req_bus.last) begin
               rsp_valid_in = 1'b1;
               found_in     = 1'b0;
               index_in     = '0;
            end
         end
         // end of stream: back to the reset state
         if (req_bus.last) begin
            win_in      = '0;
            count_in    = '0;
            reported_in = 1'b0;
         end
      end
   end

   // control and stream state
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= '0;
         count_ff     <= '0;
         reported_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         win_ff       <= win_in;
         count_ff     <= count_in;
         reported_ff  <= reported_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      found_ff <= found_in;
      index_ff <= index_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.found       = found_ff;
   assign rsp_bus.match_index = index_ff;

endmodule

`default_nettype wire
